FILE: rtl/srt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srt_pkg;

  // operation codes on func_i
  typedef enum logic [2:0] {
    F_CLEAR   = 3'd0,
    F_APPEND  = 3'd1,
    F_SORT    = 3'd2,
    F_LSEARCH = 3'd3,
    F_BSEARCH = 3'd4,
    F_DELETE  = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SORT,
    S_LSCAN,
    S_BSRCH
  } state_e;

  // what every cell does in the current cycle
  typedef enum logic [2:0] {
    C_HOLD,
    C_WRITE,
    C_SORT,
    C_CMP,
    C_SHIFT
  } cell_op_e;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] phone;
    logic [7:0]  name;
  } rec_t;

  typedef struct packed {
    cell_op_e op;
    logic     parity;
    rec_t     rec;
  } cell_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/srt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module srt_cell #(
  parameter int DEPTH = 16,
  parameter int IDX   = 0
) (
  input  wire logic                       clk_i,
  input  wire srt_pkg::cell_cmd_t         cmd_i,
  input  wire logic [$clog2(DEPTH+1)-1:0] count_i,
  input  wire logic [$clog2(DEPTH)-1:0]   pos_i,
  input  wire srt_pkg::rec_t              left_rec_i,
  input  wire logic                       left_swap_i,
  input  wire srt_pkg::rec_t              right_rec_i,
  output srt_pkg::rec_t                   rec_o,
  output logic                            swap_o,
  output logic                            eq_o,
  output logic                            lt_o
);
  import srt_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam logic PAR = logic'(IDX % 2);

  rec_t rec_q, rec_d;
  logic eq_q, lt_q;
  logic pair_live;

  // this cell and its right neighbor both hold live entries
  assign pair_live = (CW'(IDX + 1) < count_i);

  // odd-even transposition: strict compare keeps equal keys in order
  assign swap_o = (cmd_i.op == C_SORT) && (cmd_i.parity == PAR) && pair_live &&
                  ($signed(rec_q.key) > $signed(right_rec_i.key));

  always_comb begin
    rec_d = rec_q;
    case (cmd_i.op)
      C_WRITE: begin
        if (CW'(IDX) == count_i) rec_d = cmd_i.rec;
      end
      C_SORT: begin
        if (swap_o) rec_d = right_rec_i;
        else if (left_swap_i) rec_d = left_rec_i;
      end
      C_SHIFT: begin
        if ((IW'(IDX) >= pos_i) && pair_live) rec_d = right_rec_i;
      end
      default: rec_d = rec_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
    if (cmd_i.op == C_CMP) begin
      eq_q <= (rec_q.key == cmd_i.rec.key);
      lt_q <= ($signed(rec_q.key) < $signed(cmd_i.rec.key));
    end
  end

  assign rec_o = rec_q;
  assign eq_o  = eq_q;
  assign lt_o  = lt_q;

endmodule

`default_nettype wire

FILE: rtl/sorted_record_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// sorted record table: DEPTH records (key, phone, name byte) held in a row of
// cells, entries 0 .. count-1 live. a command is taken when start is high and
// busy is low; its single result shows on the result ports for exactly one
// cycle, marked by done_o, and the receiver cannot stall it, so it must take
// every transfer in that cycle. clear, append and the unused codes keep busy
// low and strobe done_o in the next cycle. sort runs odd-even transposition
// passes across neighboring cells with busy high, then strobes its result.
// linear search and delete latch a parallel key compare in all cells at the
// accepting edge and then scan the match flags one entry a cycle with busy
// high, result in the cycle after the scan ends; delete shifts the later
// entries down in the cycle the match is found. binary search walks the same
// compare flags, one probe a cycle with busy high, result in the cycle after
// the search ends. a new command may be accepted in the cycle its predecessor's
// result is strobed. keys compare as signed.
// no clearing pass after reset: table entries are undefined until written.

module sorted_record_table_unit #(
  parameter int DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  func_i,
  input  wire logic [31:0] key_i,
  input  wire logic [31:0] phone_i,
  input  wire logic [7:0]  name_byte_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic             found_o,
  output logic [3:0]       position_o,
  output logic [4:0]       entry_total_o
);
  import srt_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam logic signed [CW:0] ONE_S = (CW+1)'(1);

  state_e         state_q, state_d;
  func_e          func_q, func_d;
  logic [CW-1:0]  count_q, count_d;
  logic [CW-1:0]  ctr_q, ctr_d;
  logic signed [CW:0] lo_q, lo_d, hi_q, hi_d;
  logic signed [CW:0] mid;
  logic [IW-1:0]  mid_idx;
  logic           done_q, done_d;
  status_e        status_q, status_d;
  logic           found_q, found_d;
  logic [IW-1:0]  pos_q, pos_d;
  cell_cmd_t      cmd;
  logic [IW-1:0]  del_pos;

  rec_t           rec_w [DEPTH];
  logic [DEPTH-1:0] swap_w, eq_w, lt_w;

  // row of cells, each handing its record to both neighbors
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    rec_t left_rec, right_rec;
    logic left_swap;
    if (g == 0) begin : g_first
      assign left_rec  = '0;
      assign left_swap = 1'b0;
    end else begin : g_mid
      assign left_rec  = rec_w[g-1];
      assign left_swap = swap_w[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_rec = '0;
    end else begin : g_inner
      assign right_rec = rec_w[g+1];
    end

    srt_cell #(
      .DEPTH(DEPTH),
      .IDX  (g)
    ) u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .count_i    (count_q),
      .pos_i      (del_pos),
      .left_rec_i (left_rec),
      .left_swap_i(left_swap),
      .right_rec_i(right_rec),
      .rec_o      (rec_w[g]),
      .swap_o     (swap_w[g]),
      .eq_o       (eq_w[g]),
      .lt_o       (lt_w[g])
    );
  end

  // binary search probe, used only while lo <= hi, where the difference is not negative
  assign mid     = lo_q + ((hi_q - lo_q) >>> 1);
  assign mid_idx = mid[IW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    ctr_q    <= ctr_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    status_q <= status_d;
    found_q  <= found_d;
    pos_q    <= pos_d;
  end

  always_comb begin
    state_d    = state_q;
    func_d     = func_q;
    count_d    = count_q;
    ctr_d      = ctr_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    done_d     = 1'b0;
    status_d   = status_q;
    found_d    = found_q;
    pos_d      = pos_q;
    cmd.op     = C_HOLD;
    cmd.parity = ctr_q[0];
    cmd.rec    = '{key: key_i, phone: phone_i, name: name_byte_i};
    del_pos    = ctr_q[IW-1:0];

    case (state_q)
      S_IDLE: begin
        if (start) begin
          func_d   = func_e'(func_i);
          status_d = ST_OK;
          found_d  = 1'b0;
          pos_d    = '0;
          case (func_e'(func_i))
            F_CLEAR: begin
              count_d = '0;
              done_d  = 1'b1;
            end
            F_APPEND: begin
              done_d = 1'b1;
              if (count_q == CW'(DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                cmd.op  = C_WRITE;
                pos_d   = count_q[IW-1:0];
                count_d = count_q + CW'(1);
              end
            end
            F_SORT: begin
              ctr_d   = '0;
              state_d = S_SORT;
            end
            F_LSEARCH, F_DELETE: begin
              cmd.op  = C_CMP;
              ctr_d   = '0;
              state_d = S_LSCAN;
            end
            F_BSEARCH: begin
              cmd.op  = C_CMP;
              lo_d    = '0;
              hi_d    = $signed({1'b0, count_q}) - ONE_S;
              state_d = S_BSRCH;
            end
            default: done_d = 1'b1;
          endcase
        end
      end

      S_SORT: begin
        cmd.op = C_SORT;
        if (ctr_q == CW'(DEPTH - 1)) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          ctr_d = ctr_q + CW'(1);
        end
      end

      S_LSCAN: begin
        if (ctr_q >= count_q) begin
          status_d = ST_MISS;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else if (eq_w[ctr_q[IW-1:0]]) begin
          found_d = 1'b1;
          pos_d   = ctr_q[IW-1:0];
          done_d  = 1'b1;
          state_d = S_IDLE;
          if (func_q == F_DELETE) begin
            // later entries move down one place in this cycle
            cmd.op  = C_SHIFT;
            count_d = count_q - CW'(1);
          end
        end else begin
          ctr_d = ctr_q + CW'(1);
        end
      end

      S_BSRCH: begin
        if (lo_q > hi_q) begin
          status_d = ST_MISS;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else if (eq_w[mid_idx]) begin
          found_d = 1'b1;
          pos_d   = mid_idx;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (lt_w[mid_idx]) begin
          lo_d = mid + ONE_S;
        end else begin
          hi_d = mid - ONE_S;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_o       = found_q;
  assign position_o    = 4'(pos_q);
  assign entry_total_o = 5'(count_q);

  // the count never runs past the table size
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("live count above table depth");

  // every result transfer leaves the block ready for the next command
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == S_IDLE))
    else $error("result strobed while still busy");

  // a clear empties the table with a result in the next cycle
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (func_i == F_CLEAR)) |=> (done_q && (count_q == '0)))
    else $error("clear did not empty the table");

  // a match always reports ok
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && found_q) |-> (status_q == ST_OK))
    else $error("found flag with error status");

  // sorting never changes how many entries are live
  a_sort_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SORT) |=> $stable(count_q))
    else $error("count changed during sort");

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import srt_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int ITEM_TARGET = 850;
  localparam int CALM_ITEMS = 100;      // no idling once this few commands remain
  localparam int TAIL_CYCLES = 3 * TABLE_DEPTH + 8;
  localparam int STALL_LIMIT = 4000;

  // func codes the block leaves unused
  localparam logic [2:0] FUNC_SPARE_A = 3'd6;
  localparam logic [2:0] FUNC_SPARE_B = 3'd7;

  typedef struct {
    logic [2:0]  func;
    logic [31:0] key;
    logic [31:0] phone;
    logic [7:0]  name;
    bit          wait_drain;   // hold this command until every result is in
  } table_cmd_t;

  typedef struct {
    status_e    status;
    logic       found;
    logic [3:0] position;
    logic [4:0] total;
  } table_outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic [2:0]  func_i = F_CLEAR;
  logic [31:0] key_i = '0;
  logic [31:0] phone_i = '0;
  logic [7:0]  name_byte_i = '0;
  wire         busy;
  wire         done_o;
  wire  [1:0]  status_o;
  wire         found_o;
  wire  [3:0]  position_o;
  wire  [4:0]  entry_total_o;

  table_cmd_t     pending_cmds[$];
  table_outcome_t expected_outcomes[$];
  logic [31:0]    key_pool[6];

  // shadow copy of the table
  rec_t        shadow_rows[TABLE_DEPTH];
  int unsigned shadow_live = 0;

  bit          taken = 1'b0;
  int unsigned idle_left = 0;
  int unsigned stall_cycles = 0;
  int unsigned mismatch_count = 0;

  always #2 clk_i = ~clk_i;

  sorted_record_table_unit #(
    .DEPTH(TABLE_DEPTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .key_i        (key_i),
    .phone_i      (phone_i),
    .name_byte_i  (name_byte_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .found_o      (found_o),
    .position_o   (position_o),
    .entry_total_o(entry_total_o)
  );

  // first live row whose key equals k, -1 if none
  function automatic int scan_rows(logic [31:0] k);
    for (int i = 0; i < shadow_live; i++) begin
      if (shadow_rows[i].key == k) return i;
    end
    return -1;
  endfunction

  // halving probe on the rows as they stand, sorted or not
  function automatic int probe_rows(logic [31:0] k);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = int'(shadow_live) - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if ($signed(k) > $signed(shadow_rows[mid].key)) lo = mid + 1;
      else if ($signed(k) < $signed(shadow_rows[mid].key)) hi = mid - 1;
      else return mid;
    end
    return -1;
  endfunction

  // stable insertion sort by signed key, whole rows move
  function automatic void sort_rows();
    rec_t row;
    int   j;
    for (int i = 1; i < shadow_live; i++) begin
      row = shadow_rows[i];
      j = i;
      while (j > 0 && $signed(shadow_rows[j - 1].key) > $signed(row.key)) begin
        shadow_rows[j] = shadow_rows[j - 1];
        j--;
      end
      shadow_rows[j] = row;
    end
  endfunction

  // runs one command on the shadow table and gives its result
  function automatic table_outcome_t apply_table_command(table_cmd_t cmd);
    table_outcome_t res;
    int             hit;
    res.status = ST_OK;
    res.found = 1'b0;
    res.position = '0;
    case (cmd.func)
      F_CLEAR: shadow_live = 0;
      F_APPEND: begin
        if (shadow_live >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_rows[shadow_live] = '{key: cmd.key, phone: cmd.phone, name: cmd.name};
          res.position = shadow_live[3:0];
          shadow_live++;
        end
      end
      F_SORT: sort_rows();
      F_LSEARCH, F_BSEARCH, F_DELETE: begin
        hit = (cmd.func == F_BSEARCH) ? probe_rows(cmd.key) : scan_rows(cmd.key);
        if (hit < 0) begin
          res.status = ST_MISS;
        end else begin
          res.found = 1'b1;
          res.position = hit[3:0];
          if (cmd.func == F_DELETE) begin
            // later rows slide down over the deleted one
            for (int j = hit; j + 1 < shadow_live; j++) shadow_rows[j] = shadow_rows[j + 1];
            shadow_live--;
          end
        end
      end
      default: ;
    endcase
    res.total = shadow_live[4:0];
    return res;
  endfunction

  function automatic void queue_cmd(logic [2:0] func, logic [31:0] key,
                                    logic [31:0] phone, logic [7:0] name, bit wait_drain);
    pending_cmds.push_back('{func: func, key: key, phone: phone, name: name,
                             wait_drain: wait_drain});
  endfunction

  // mostly keys from the episode pool, so searches and deletes hit
  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 3) != 0) return key_pool[$urandom_range(0, 5)];
    return $urandom;
  endfunction

  // driver: a command stays up until the block takes it
  always @(negedge clk_i) begin
    table_cmd_t cmd;
    if (rst_ni && !(start && !taken)) begin
      if (idle_left != 0) begin
        idle_left = idle_left - 1;
        start <= 1'b0;
      end else if (pending_cmds.size() != 0 &&
                   !(pending_cmds[0].wait_drain && expected_outcomes.size() != 0)) begin
        cmd = pending_cmds.pop_front();
        func_i <= cmd.func;
        key_i <= cmd.key;
        phone_i <= cmd.phone;
        name_byte_i <= cmd.name;
        start <= 1'b1;
        // idle bursts come in stretches, none near the end
        if (pending_cmds.size() > CALM_ITEMS && (pending_cmds.size() / 80) % 3 != 0 &&
            $urandom_range(0, 3) == 0) begin
          idle_left = $urandom_range(1, 10);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check the strobed result, then log the transfer taken at this edge
  always @(posedge clk_i) begin
    table_outcome_t want;
    table_cmd_t     cmd;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_outcomes.size() == 0) begin
          $error("result with nothing expected");
          mismatch_count++;
        end else begin
          want = expected_outcomes.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            mismatch_count++;
          end
          if (found_o !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found_o);
            mismatch_count++;
          end
          if (position_o !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, position_o);
            mismatch_count++;
          end
          if (entry_total_o !== want.total) begin
            $error("entry_total: expected %0d, got %0d", want.total, entry_total_o);
            mismatch_count++;
          end
        end
      end
      taken <= start && !busy;
      if (start && !busy) begin
        cmd = '{func: func_i, key: key_i, phone: phone_i, name: name_byte_i, wait_drain: 1'b0};
        expected_outcomes.push_back(apply_table_command(cmd));
      end
      if (done_o || (start && !busy)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("sorted_record_table_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int n_append;
    int n_ops;
    int sel;

    // directed: empty table, extremes, duplicates, unsorted probe, spare codes
    queue_cmd(F_CLEAR, '0, '0, '0, 1'b1);
    queue_cmd(FUNC_SPARE_A, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b0);
    queue_cmd(F_BSEARCH, '0, '0, '0, 1'b0);
    queue_cmd(F_LSEARCH, '0, '0, '0, 1'b0);
    queue_cmd(F_DELETE, '0, '0, '0, 1'b0);
    queue_cmd(F_SORT, '0, '0, '0, 1'b0);
    queue_cmd(F_APPEND, 32'h7FFF_FFFF, 32'h8000_0000, 8'hFF, 1'b0);
    queue_cmd(F_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, 8'h00, 1'b0);
    queue_cmd(F_APPEND, 32'h0000_0000, 32'hFFFF_FFFF, 8'h55, 1'b0);
    queue_cmd(F_APPEND, 32'hFFFF_FFFF, 32'h0000_0000, 8'hAA, 1'b0);
    queue_cmd(F_APPEND, 32'h0000_0000, 32'h0000_0001, 8'h01, 1'b0);
    queue_cmd(F_BSEARCH, 32'h0000_0000, '0, '0, 1'b0);
    queue_cmd(F_LSEARCH, 32'h0000_0000, '0, '0, 1'b0);
    queue_cmd(F_LSEARCH, 32'h0000_0005, '0, '0, 1'b0);
    queue_cmd(F_SORT, '0, '0, '0, 1'b0);
    queue_cmd(F_BSEARCH, 32'h8000_0000, '0, '0, 1'b0);
    queue_cmd(F_BSEARCH, 32'h7FFF_FFFF, '0, '0, 1'b0);
    queue_cmd(F_DELETE, 32'h0000_0000, '0, '0, 1'b0);
    queue_cmd(F_DELETE, 32'h0000_3039, '0, '0, 1'b0);
    queue_cmd(F_LSEARCH, 32'hFFFF_FFFF, '0, '0, 1'b0);
    queue_cmd(FUNC_SPARE_B, 32'h0000_0000, '0, '0, 1'b0);
    queue_cmd(F_CLEAR, '0, '0, '0, 1'b0);
    queue_cmd(F_LSEARCH, 32'h7FFF_FFFF, '0, '0, 1'b0);

    // random episodes: fill from a small key pool, maybe sort, then work on it
    while (pending_cmds.size() < ITEM_TARGET) begin
      for (int i = 0; i < 6; i++) begin
        key_pool[i] = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 6) - 3;
      end
      if ($urandom_range(0, 9) < 7) begin
        queue_cmd(F_CLEAR, $urandom, $urandom, 8'($urandom), $urandom_range(0, 2) == 0);
      end
      n_append = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 19) : $urandom_range(0, 10);
      for (int i = 0; i < n_append; i++) begin
        queue_cmd(F_APPEND, pick_key(), $urandom, 8'($urandom), 1'b0);
      end
      if ($urandom_range(0, 1) != 0) queue_cmd(F_SORT, $urandom, $urandom, 8'($urandom), 1'b0);
      n_ops = $urandom_range(3, 12);
      for (int i = 0; i < n_ops; i++) begin
        sel = $urandom_range(0, 15);
        if (sel < 4) queue_cmd(F_LSEARCH, pick_key(), $urandom, 8'($urandom), 1'b0);
        else if (sel < 8) queue_cmd(F_BSEARCH, pick_key(), $urandom, 8'($urandom), 1'b0);
        else if (sel < 11) queue_cmd(F_DELETE, pick_key(), $urandom, 8'($urandom), 1'b0);
        else if (sel < 13) queue_cmd(F_APPEND, pick_key(), $urandom, 8'($urandom), 1'b0);
        else if (sel < 14) queue_cmd(F_SORT, $urandom, $urandom, 8'($urandom), 1'b0);
        else queue_cmd(3'($urandom_range(0, 7)), $urandom, $urandom, 8'($urandom), 1'b0);
      end
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || start || expected_outcomes.size() != 0) begin
      @(posedge clk_i);
    end
    // let any stray strobe show up
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("sorted_record_table_unit: match");
    end else begin
      $display("sorted_record_table_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/srt_pkg.sv
rtl/srt_cell.sv
rtl/sorted_record_table_unit.sv
test/testbench.sv
